[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the spin update block.
// Depends on nothing; take it in by include before the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/ising_pkg.sv]
// Types and constants of the Ising Metropolis spin update block.
// Used by the top level; depends on nothing.
package ising_pkg;

   localparam int SIDE_DEFAULT = 64;

   // Input field widths (fixed by the stream format)
   localparam int FIELD_W  = 6;
   localparam int FRAC_W   = 32;
   localparam int LEVEL_W  = 33;
   localparam int ENERGY_W = 15;
   localparam int MAGNET_W = 14;
   localparam int LEVELS   = 5;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [2:0] {
      CSR_LEVEL_0 = 3'd0,
      CSR_LEVEL_1 = 3'd1,
      CSR_LEVEL_2 = 3'd2,
      CSR_LEVEL_3 = 3'd3,
      CSR_LEVEL_4 = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ2 = 4'b0100,
      ST_EVAL  = 4'b1000
   } state_type;

endpackage

[rtl/core/ising_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module ising_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_a_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic                     rd_b_en,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem[rd_b_addr];
      end
   end

endmodule

[rtl/core/ising_metropolis_spin_update_top.sv]
// Top level of the Ising Metropolis spin update block: registers, sequencer, totals.
// Depends on ising_pkg and ising_ram.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  req      | in  | req_tvalid/req_tready  | tuser kind; tdata row,column,spin,fraction
//  rsp      | out | rsp_tvalid/rsp_tready  | tdata flipped, energy, magnetization
//  csr      | in  | APB psel/penable       | five 33-bit acceptance levels at 8*i
//
// The spin grid lives in one RAM of SIDE rows, one SIDE-bit word per row.
// For each item, rows r and r-1 are read on the two read ports, then row r+1,
// then the spin is decided and row r written back.
// After reset a clearing pass writes every row to all ones; no transaction is
// taken on req meanwhile, csr writes are taken as ever.
// A stalled rsp holds the last item in its decision cycle; the next item may be
// accepted while a result waits.
module ising_metropolis_spin_update_top #(
   parameter int SIDE = ising_pkg::SIDE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: row[5:0], column[11:6], spin_value[12], random_fraction[44:13], zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ising_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: kind[0]
   input  logic                                 req_tuser,
   // rsp_tdata: flipped[0], energy[15:1], magnetization[29:16], zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ising_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ising_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ising_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ising_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   import ising_pkg::*;

   localparam int ROW_W       = $clog2(SIDE);
   localparam int FIELD_RANGE = 1 << FIELD_W;
   localparam int E_RESET_I   = -2 * SIDE * SIDE;
   localparam int M_RESET_I   = SIDE * SIDE;
   localparam logic [ENERGY_W-1:0] E_RESET = ENERGY_W'(E_RESET_I);
   localparam logic [MAGNET_W-1:0] M_RESET = MAGNET_W'(M_RESET_I);
   localparam logic [ROW_W-1:0]    LAST    = ROW_W'(SIDE - 1);

   // Reduction of a 6-bit site field modulo SIDE
   logic [ROW_W-1:0] mod_tab [FIELD_RANGE];
   for (genvar i = 0; i < FIELD_RANGE; i++) begin : g_mod
      localparam int MODV = i % SIDE;
      assign mod_tab[i] = ROW_W'(MODV);
   end

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0]  level_ff [LEVELS];
   logic [ROW_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [ROW_W-1:0]    row_ff, col_ff;
   logic                kind_ff, want_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic                up_bit_ff;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [MAGNET_W-1:0] magnet_ff, magnet_in;
   logic                flip_ff, flip_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                req_accept;
   logic [ROW_W-1:0]    req_row, req_col, up_row, down_row, col_left, col_right;
   logic                go;

   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_addr;
   logic [SIDE-1:0]     ram_wr_data;
   logic [ROW_W-1:0]    ram_b_addr;
   logic [SIDE-1:0]     row_word, b_word;

   logic                site_bit, left_bit, right_bit, down_bit;
   logic [2:0]          ones;
   logic [2:0]          lvl_idx;
   logic                flip;

   // ---------------- configuration port ----------------
   csr_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (csr_index)
         CSR_LEVEL_0: csr_prdata = CSR_DATA_W'(level_ff[0]);
         CSR_LEVEL_1: csr_prdata = CSR_DATA_W'(level_ff[1]);
         CSR_LEVEL_2: csr_prdata = CSR_DATA_W'(level_ff[2]);
         CSR_LEVEL_3: csr_prdata = CSR_DATA_W'(level_ff[3]);
         CSR_LEVEL_4: csr_prdata = CSR_DATA_W'(level_ff[4]);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            level_ff[i] <= LEVEL_W'(64'h1_0000_0000);
         end
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEVEL_0: level_ff[0] <= csr_pwdata[LEVEL_W-1:0];
            CSR_LEVEL_1: level_ff[1] <= csr_pwdata[LEVEL_W-1:0];
            CSR_LEVEL_2: level_ff[2] <= csr_pwdata[LEVEL_W-1:0];
            CSR_LEVEL_3: level_ff[3] <= csr_pwdata[LEVEL_W-1:0];
            CSR_LEVEL_4: level_ff[4] <= csr_pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- address generation ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign req_row    = mod_tab[req_tdata[FIELD_W-1:0]];
   assign req_col    = mod_tab[req_tdata[2*FIELD_W-1:FIELD_W]];
   assign up_row     = (req_row == '0) ? LAST : req_row - ROW_W'(1);
   assign down_row   = (row_ff == LAST) ? '0 : row_ff + ROW_W'(1);
   assign col_left   = (col_ff == '0) ? LAST : col_ff - ROW_W'(1);
   assign col_right  = (col_ff == LAST) ? '0 : col_ff + ROW_W'(1);
   assign ram_b_addr = (state_ff == ST_READ2) ? down_row : up_row;

   ising_ram #(
      .WIDTH (SIDE),
      .DEPTH (SIDE)
   ) u_spin_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_a_en   (req_accept),
      .rd_a_addr (req_row),
      .rd_a_data (row_word),
      .rd_b_en   (req_accept | (state_ff == ST_READ2)),
      .rd_b_addr (ram_b_addr),
      .rd_b_data (b_word)
   );

   // ---------------- decision ----------------
   assign site_bit  = row_word[col_ff];
   assign left_bit  = row_word[col_left];
   assign right_bit = row_word[col_right];
   assign down_bit  = b_word[col_ff];
   assign ones      = 3'(up_bit_ff) + 3'(down_bit) + 3'(left_bit) + 3'(right_bit);
   // A +1 site selects its level by the count of +1 neighbors, a -1 site by the rest
   assign lvl_idx   = site_bit ? ones : 3'd4 - ones;
   assign flip      = kind_ff ? (want_ff != site_bit)
                              : ({1'b0, frac_ff} <= level_ff[lvl_idx]);
   assign go        = (state_ff == ST_EVAL) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = row_ff;
      ram_wr_data = row_word;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '1;
      end else if (go & flip) begin
         ram_wr_en        = 1'b1;
         ram_wr_data[col_ff] = ~site_bit;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      energy_in    = energy_ff;
      magnet_in    = magnet_ff;
      flip_in      = flip_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ROW_W'(1);
            if (clr_cnt_ff == LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ2;
            end
         end
         ST_READ2: state_in = ST_EVAL;
         ST_EVAL: begin
            if (go) begin
               state_in     = ST_IDLE;
               flip_in      = flip;
               rsp_valid_in = 1'b1;
               if (flip) begin
                  // Energy moves by 4*level index - 8, magnetization by twice the new spin
                  energy_in = energy_ff + ENERGY_W'({lvl_idx, 2'b00}) - ENERGY_W'(8);
                  magnet_in = site_bit ? magnet_ff - MAGNET_W'(2)
                                       : magnet_ff + MAGNET_W'(2);
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         energy_ff    <= E_RESET;
         magnet_ff    <= M_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         energy_ff    <= energy_in;
         magnet_ff    <= magnet_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      if (req_accept) begin
         row_ff  <= req_row;
         col_ff  <= req_col;
         kind_ff <= req_tuser;
         want_ff <= req_tdata[2*FIELD_W];
         frac_ff <= req_tdata[2*FIELD_W+FRAC_W:2*FIELD_W+1];
      end
      // Hold the up neighbor before port b moves on to the row below
      if (state_ff == ST_READ2) begin
         up_bit_ff <= b_word[col_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - MAGNET_W - ENERGY_W - 1)'(0),
                        magnet_ff, energy_ff, flip_ff};

endmodule

[rtl/core/ising_checker.sv]
// Port-level checker of the Ising spin update top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ising_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Handshake: a stalled result stays and holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "rsp payload changed while stalled")
   // One item at a time: ready drops after each transaction
   `ASSERT_CLK(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "req taken in back-to-back cycles")
   // Energy only moves in steps of four from an even reset value
   `ASSERT_ALWAYS(a_energy_even, clock, rsp_tvalid |-> !rsp_tdata[1], "odd energy reported")

endmodule

bind ising_metropolis_spin_update_top ising_checker u_ising_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the Ising Metropolis spin update block: flip attempts and direct
// spin writes go in on req, a local lattice model predicts each rsp transaction but where a probe gives its own.
// Depends on ising_pkg and ising_metropolis_spin_update_top.
module tb_top;
   import ising_pkg::*;

   localparam int SIDE = SIDE_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS = 100;
   localparam int MAX_REPORTS = 10;
   localparam int DIRECTED_ROWS = 24;
   localparam logic KIND_FLIP = 1'b0;
   localparam logic KIND_SET = 1'b1;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 33'h1_0000_0000;
   localparam int CFG_NONE = -1;
   localparam int CFG_ZERO = 0;
   localparam int CFG_OVER = 1;
   localparam int CFG_MIXED = 2;

   typedef struct packed {
      logic flipped;
      logic signed [ENERGY_W-1:0] energy;
      logic signed [MAGNET_W-1:0] magnet;
   } spin_result_type;

   typedef struct packed {
      int cfg;
      logic kind;
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] col;
      logic spin;
      logic [FRAC_W-1:0] frac;
      logic typed;
      spin_result_type want;
   } probe_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // local copy of the lattice, totals and thresholds
   logic [SIDE-1:0] lattice [SIDE];
   logic signed [ENERGY_W-1:0] energy_sum;
   logic signed [MAGNET_W-1:0] magnet_sum;
   logic [LEVEL_W-1:0] level [LEVELS];
   spin_result_type pending_results [$];

   int errors = 0;
   int sent_items = 0;
   int set_items = 0;
   int checked = 0;
   int flips_seen = 0;
   int settings = 0;
   int idle_cycles = 0;
   bit steady = 1'b0;

   csr_index_type level_reg [LEVELS] =
      '{CSR_LEVEL_0, CSR_LEVEL_1, CSR_LEVEL_2, CSR_LEVEL_3, CSR_LEVEL_4};

   logic [CSR_DATA_W-1:0] level_sets [3][LEVELS] = '{
      '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0},
      '{64'hA5A5_A5A5_FFFF_FFFF, 64'hA5A5_A5A5_FFFF_FFFF, 64'hA5A5_A5A5_FFFF_FFFF,
        64'hA5A5_A5A5_FFFF_FFFF, 64'hA5A5_A5A5_FFFF_FFFF},
      '{64'h1_0000_0000, 64'hC000_0000, 64'h8000_0000, 64'h1000_0000, 64'h1}
   };

   // kind, site, spin, fraction; expected result only where it is obvious from reset
   probe_type probes [DIRECTED_ROWS] = '{
      '{CFG_NONE,  KIND_FLIP, 6'd0,  6'd0,  1'b0, 32'h0000_0000, 1'b1,
        '{1'b1, -15'sd8184, 14'sd4094}},
      '{CFG_NONE,  KIND_FLIP, 6'd0,  6'd0,  1'b1, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, -15'sd8192, 14'sd4096}},
      '{CFG_NONE,  KIND_SET,  6'd63, 6'd63, 1'b1, 32'h0000_0000, 1'b1,
        '{1'b0, -15'sd8192, 14'sd4096}},
      '{CFG_NONE,  KIND_SET,  6'd63, 6'd63, 1'b0, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, -15'sd8184, 14'sd4094}},
      '{CFG_NONE,  KIND_FLIP, 6'd0,  6'd63, 1'b1, 32'h0000_0000, 1'b0, '0},
      '{CFG_ZERO,  KIND_FLIP, 6'd10, 6'd10, 1'b0, 32'h0000_0001, 1'b1,
        '{1'b0, -15'sd8180, 14'sd4092}},
      '{CFG_NONE,  KIND_FLIP, 6'd10, 6'd10, 1'b0, 32'h0000_0000, 1'b1,
        '{1'b1, -15'sd8172, 14'sd4090}},
      '{CFG_NONE,  KIND_FLIP, 6'd10, 6'd10, 1'b1, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, -15'sd8172, 14'sd4090}},
      '{CFG_NONE,  KIND_SET,  6'd10, 6'd10, 1'b1, 32'h0000_0000, 1'b1,
        '{1'b1, -15'sd8180, 14'sd4092}},
      '{CFG_NONE,  KIND_FLIP, 6'd0,  6'd63, 1'b0, 32'h0000_0000, 1'b0, '0},
      '{CFG_OVER,  KIND_FLIP, 6'd20, 6'd20, 1'b0, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, -15'sd8176, 14'sd4092}},
      '{CFG_NONE,  KIND_FLIP, 6'd21, 6'd20, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd20, 6'd21, 1'b1, 32'hFFFF_FFFF, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd21, 6'd21, 1'b0, 32'h8000_0000, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd20, 6'd20, 1'b0, 32'h1234_5678, 1'b0, '0},
      '{CFG_MIXED, KIND_SET,  6'd31, 6'd32, 1'b0, 32'h0000_0000, 1'b0, '0},
      '{CFG_NONE,  KIND_SET,  6'd32, 6'd31, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
      '{CFG_NONE,  KIND_SET,  6'd32, 6'd33, 1'b0, 32'h0000_0000, 1'b0, '0},
      '{CFG_NONE,  KIND_SET,  6'd33, 6'd32, 1'b0, 32'h0000_0000, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd32, 6'd32, 1'b0, 32'hFFFF_FFFF, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd32, 6'd32, 1'b0, 32'h0000_0000, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd32, 6'd32, 1'b0, 32'h0000_0002, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd32, 6'd32, 1'b0, 32'h0000_0002, 1'b0, '0},
      '{CFG_NONE,  KIND_FLIP, 6'd32, 6'd32, 1'b0, 32'h0000_0001, 1'b0, '0}
   };

   ising_metropolis_spin_update_top #(.SIDE(SIDE)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decide one site against the local lattice and advance the totals.
   function automatic spin_result_type metropolis_update(logic kind, logic [FIELD_W-1:0] row,
         logic [FIELD_W-1:0] col, logic spin, logic [FRAC_W-1:0] frac);
      int r, c, up, down, west, east, s_old, nsum, product;
      logic flip;
      spin_result_type res;
      r = row % SIDE;
      c = col % SIDE;
      up = (r + SIDE - 1) % SIDE;
      down = (r + 1) % SIDE;
      west = (c + SIDE - 1) % SIDE;
      east = (c + 1) % SIDE;
      s_old = lattice[r][c] ? 1 : -1;
      nsum = (lattice[up][c] ? 1 : -1) + (lattice[down][c] ? 1 : -1)
           + (lattice[r][west] ? 1 : -1) + (lattice[r][east] ? 1 : -1);
      // product of the old spin and its neighbors picks the threshold
      product = s_old * nsum;
      if (kind == KIND_FLIP) begin
         flip = ({1'b0, frac} <= level[2 + product / 2]);
      end else begin
         flip = (spin != lattice[r][c]);
      end
      if (flip) begin
         lattice[r][c] = ~lattice[r][c];
         energy_sum = ENERGY_W'(energy_sum + 2 * product);
         magnet_sum = MAGNET_W'(magnet_sum - 2 * s_old);
      end
      res.flipped = flip;
      res.energy = energy_sum;
      res.magnet = magnet_sum;
      return res;
   endfunction

   task automatic send_item(logic kind, logic [FIELD_W-1:0] row, logic [FIELD_W-1:0] col,
         logic spin, logic [FRAC_W-1:0] frac, logic typed, spin_result_type want);
      int gap;
      spin_result_type res;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_DATA_W - 2 * FIELD_W - 1 - FRAC_W){1'b0}}, frac, spin, col, row};
      do @(posedge clock); while (!req_tready);
      res = metropolis_update(kind, row, col, spin, frac);
      pending_results.push_back(typed ? want : res);
      sent_items++;
      if (kind == KIND_SET) set_items++;
   endtask

   // Drop valid and wait until every result is back and the pipeline is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_levels(logic [CSR_DATA_W-1:0] values [LEVELS]);
      for (int i = 0; i < LEVELS; i++) begin
         @(posedge clock);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {level_reg[i], 3'b000};
         csr_pwdata <= values[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         level[i] = values[i][LEVEL_W-1:0];
      end
      settings++;
   endtask

   initial begin : result_check
      int stall;
      spin_result_type got, want;
      wait (reset == 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.flipped = rsp_tdata[0];
         got.energy = rsp_tdata[ENERGY_W:1];
         got.magnet = rsp_tdata[ENERGY_W + MAGNET_W:ENERGY_W + 1];
         checked++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result: flipped %0d energy %0d magnetization %0d",
                        got.flipped, got.energy, got.magnet);
         end else begin
            want = pending_results.pop_front();
            if (got.flipped !== want.flipped || got.energy !== want.energy
                || got.magnet !== want.magnet) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("result %0d: expected flipped %0d energy %0d magnetization %0d, %s",
                           checked, want.flipped, want.energy, want.magnet,
                           $sformatf("got flipped %0d energy %0d magnetization %0d",
                                     got.flipped, got.energy, got.magnet));
            end
            if (got.flipped === 1'b1) flips_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("ising_metropolis_spin_update_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic kind, spin;
      logic [FIELD_W-1:0] row, col;
      logic [FRAC_W-1:0] frac;
      logic [CSR_DATA_W-1:0] new_levels [LEVELS];
      int set_pct, base_row, base_col, pick;
      for (int i = 0; i < SIDE; i++) lattice[i] = '1;
      energy_sum = ENERGY_W'(-2 * SIDE * SIDE);
      magnet_sum = MAGNET_W'(SIDE * SIDE);
      for (int i = 0; i < LEVELS; i++) level[i] = LEVEL_ONE;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (probes[i].cfg != CFG_NONE) begin
            settle();
            write_levels(level_sets[probes[i].cfg]);
         end
         send_item(probes[i].kind, probes[i].row, probes[i].col, probes[i].spin,
                   probes[i].frac, probes[i].typed, probes[i].want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         for (int i = 0; i < LEVELS; i++) begin
            case (phase % 4)
               0: new_levels[i] = ($urandom_range(0, 7) == 0) ? {31'h0, LEVEL_ONE}
                                                              : {32'h0, $urandom};
               1: new_levels[i] = (i < 3) ? {31'h0, LEVEL_ONE} : {32'h0, $urandom >> (i * 2)};
               2: begin
                  pick = $urandom_range(0, 2);
                  new_levels[i] = (pick == 0) ? 64'h0 :
                                  (pick == 1) ? {31'h0, LEVEL_ONE} : {$urandom, 32'hFFFF_FFFF};
               end
               default: new_levels[i] = {$urandom, $urandom};
            endcase
         end
         write_levels(new_levels);
         steady = (phase % 3 == 1);
         // a small window (wrapping at the edges) builds up mixed neighborhoods
         base_row = $urandom_range(0, SIDE - 1);
         base_col = $urandom_range(0, SIDE - 1);
         set_pct = (phase == 0) ? 60 : 25;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = ($urandom_range(0, 99) < set_pct) ? KIND_SET : KIND_FLIP;
            if ($urandom_range(0, 1) == 1) begin
               row = FIELD_W'((base_row + $urandom_range(0, 7)) % SIDE);
               col = FIELD_W'((base_col + $urandom_range(0, 7)) % SIDE);
            end else begin
               row = FIELD_W'($urandom_range(0, SIDE - 1));
               col = FIELD_W'($urandom_range(0, SIDE - 1));
            end
            spin = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, LEVELS - 1);
            case ($urandom_range(0, 7))
               0: frac = '0;
               1: frac = '1;
               2, 3: frac = level[pick][FRAC_W-1:0] + FRAC_W'($urandom_range(0, 2)) - 1;
               default: frac = $urandom;
            endcase
            send_item(kind, row, col, spin, frac, 1'b0, '0);
         end
      end
      steady = 1'b0;
      settle();

      $display("covered %0d requests (%0d direct spin writes) under %0d threshold settings",
               sent_items, set_items, settings);
      $display("checked %0d results, %0d of them flips, %0d mismatches",
               checked, flips_seen, errors);
      if (errors == 0) begin
         $display("ising_metropolis_spin_update_top: match");
      end else begin
         $display("ising_metropolis_spin_update_top: mismatch");
      end
      $finish;
   end

endmodule
